// File: src/gbcg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbcg_pkg: shared types and constants
// Register map, command and status groups and the 2^(-k/16) table used by the
// gesture gate controller and datapath.
// ----------------------------------------------------------------------------
package gbcg_pkg;

  localparam int unsigned POS_W    = 24;
  localparam int unsigned VEL_W    = 25;
  localparam int unsigned ACC_W    = 26;
  localparam int unsigned SUM_W    = 52;
  localparam int unsigned MAG_W    = 26;
  localparam int unsigned MID_W    = 23;
  localparam int unsigned CONF_W   = 17;
  localparam int unsigned QUO_W    = 22;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned ROOT_STEPS = 26;
  localparam int unsigned DIV_STEPS  = 22;
  localparam int unsigned SQ_STEPS   = 3;

  localparam logic [CONF_W-1:0] ONE_Q16 = 17'd65536;

  localparam logic [22:0] MIDPOINT_RST = 23'd3277;
  localparam logic [16:0] WEIGHT_RST   = 17'd13107;
  localparam logic [16:0] UNBLOCK_RST  = 17'd39322;
  localparam logic [16:0] BLOCK_RST    = 17'd26214;
  localparam logic [15:0] TIMEOUT_RST  = 16'd500;

  typedef enum logic [2:0] {
    REG_MIDPOINT = 3'd0,
    REG_WEIGHT   = 3'd1,
    REG_UNBLOCK  = 3'd2,
    REG_BLOCK    = 3'd3,
    REG_TIMEOUT  = 3'd4
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FIRST, ST_SQ, ST_RINIT, ST_ROOT, ST_DINIT, ST_DIV,
    ST_EXP, ST_MIX0, ST_MIX1, ST_UPD, ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    MUL_SQ,
    MUL_KEEP,
    MUL_NEW
  } mul_sel_e;

  typedef struct packed {
    logic [22:0] accel_midpoint;
    logic [16:0] smoothing_weight;
    logic [16:0] unblock_level;
    logic [16:0] block_level;
    logic [15:0] grip_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic     load;
    logic     first;
    mul_sel_e mul_sel;
    logic [1:0] sq_idx;
    logic     acc_clr;
    logic     acc_en;
    logic     root_init;
    logic     root_step;
    logic     div_init;
    logic     div_step;
    logic     exp_en;
    logic     upd;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic pose;
    logic hist_valid;
    logic out_free;
  } status_t;

  function automatic logic [16:0] exp2_neg(input logic [4:0] k);
    logic [16:0] v;
    case (k)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44380;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      5'd16:   v = 17'd32768;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

// File: src/gbcg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbcg_ctrl: sequencing controller
// Walks one frame through squaring, root, divide, exponent and smoothing.
// ----------------------------------------------------------------------------
module gbcg_ctrl import gbcg_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    cmd_o.mul_sel = MUL_SQ;
    cmd_o.sq_idx  = cnt_q[1:0];
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d = '0;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        // Picks the path from registered status after capture, FIRST and UPD.
        if (status_i.pose && !status_i.hist_valid) begin
          state_d = ST_FIRST;
        end else if (status_i.pose && cnt_q == '0) begin
          state_d = ST_SQ;
        end else if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_FIRST: begin
        cmd_o.first = 1'b1;
        cnt_d = CNT_W'(1);
        state_d = ST_OUT;
      end
      ST_SQ: begin
        cmd_o.acc_en  = 1'b1;
        cmd_o.acc_clr = (cnt_q == '0);
        if (cnt_q == CNT_W'(SQ_STEPS - 1)) begin
          cnt_d = '0;
          state_d = ST_RINIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_RINIT: begin
        cmd_o.root_init = 1'b1;
        state_d = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (cnt_q == CNT_W'(ROOT_STEPS - 1)) begin
          cnt_d = '0;
          state_d = ST_DINIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DINIT: begin
        cmd_o.div_init = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          cnt_d = '0;
          state_d = ST_EXP;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_EXP: begin
        cmd_o.exp_en = 1'b1;
        state_d = ST_MIX0;
      end
      ST_MIX0: begin
        cmd_o.mul_sel = MUL_KEEP;
        cmd_o.acc_en  = 1'b1;
        cmd_o.acc_clr = 1'b1;
        state_d = ST_MIX1;
      end
      ST_MIX1: begin
        cmd_o.mul_sel = MUL_NEW;
        cmd_o.acc_en  = 1'b1;
        state_d = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.upd = 1'b1;
        cnt_d = CNT_W'(1);
        state_d = ST_OUT;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: src/gbcg_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbcg_datapath: motion confidence and gesture datapath
// Holds history, a shared multiplier, the root and divide units, the
// exponent stage, the gesture latches and the output word register.
// ----------------------------------------------------------------------------
module gbcg_datapath import gbcg_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  input  cmd_t          cmd_i,
  output status_t       status_o,
  input  logic          pose_i,
  input  logic [111:0]  data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [31:0]   out_data_o
);

  logic signed [POS_W-1:0] prev_pos_q [3];
  logic signed [VEL_W-1:0] prev_vel_q [3];
  logic signed [VEL_W-1:0] vel_q [3];
  logic signed [ACC_W-1:0] accl_q [3];
  logic signed [POS_W-1:0] cap_pos_q [3];
  logic                    hist_q;
  logic [CONF_W-1:0]       conf_q;
  logic                    blk_q;
  logic [31:0]             lft_q;
  logic [4:0]              held_q;

  logic        pose_q, fist_q, palm_q, trg_q;
  logic [2:0]  btn_q;
  logic [31:0] now_q;

  logic [SUM_W-1:0] sum_q;
  logic [SUM_W-1:0] rv_q, rres_q, rbit_q;
  logic             sat_q;
  logic [MID_W-1:0] rem_q;
  logic [QUO_W-1:0] dvd_q, quo_q;
  logic [CONF_W-1:0] inst_q;

  logic        out_valid_q;
  logic [31:0] out_data_q;

  logic signed [POS_W-1:0] pos_in [3];
  assign pos_in[0] = signed'(data_i[23:0]);
  assign pos_in[1] = signed'(data_i[47:24]);
  assign pos_in[2] = signed'(data_i[71:48]);

  // Shared multiplier.
  logic [16:0] w_sat;
  assign w_sat = (cfg_i.smoothing_weight > 17'(ONE_Q16)) ? ONE_Q16 : cfg_i.smoothing_weight;

  logic signed [ACC_W-1:0] ma, mb;
  logic signed [2*ACC_W-1:0] prod;
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_KEEP: begin
        ma = signed'({9'd0, conf_q});
        mb = signed'({9'd0, 17'(ONE_Q16 - w_sat)});
      end
      MUL_NEW: begin
        ma = signed'({9'd0, inst_q});
        mb = signed'({9'd0, w_sat});
      end
      default: begin
        ma = accl_q[cmd_i.sq_idx];
        mb = accl_q[cmd_i.sq_idx];
      end
    endcase
  end
  assign prod = ma * mb;

  // Root step.
  logic [SUM_W:0] rtry;
  assign rtry = {1'b0, rres_q} + {1'b0, rbit_q};

  // Divide setup and step.
  logic [MID_W-1:0] mid;
  logic [MAG_W-1:0] mag;
  logic [MID_W:0]   dtry;
  assign mid  = (cfg_i.accel_midpoint == '0) ? MID_W'(1) : cfg_i.accel_midpoint;
  assign mag  = rres_q[MAG_W-1:0];
  assign dtry = {rem_q, dvd_q[QUO_W-1]};

  // Exponent stage.
  logic [16:0] t0, t1, ev;
  logic [11:0] drop;
  logic [23:0] dprod;
  logic [5:0]  ip;
  assign t0    = exp2_neg({1'b0, quo_q[15:12]});
  assign t1    = exp2_neg(5'({1'b0, quo_q[15:12]} + 5'd1));
  assign drop  = 12'(t0 - t1);
  assign dprod = drop * quo_q[11:0];
  assign ev    = t0 - 17'(12'((dprod + 24'd2048) >> 12));
  assign ip    = quo_q[21:16];

  // Smoothing result and hysteresis.
  logic [SUM_W-1:0] rnd;
  logic [CONF_W-1:0] conf_new;
  assign rnd      = (sum_q + SUM_W'(32768)) >> 16;
  assign conf_new = (rnd > SUM_W'(ONE_Q16)) ? ONE_Q16 : rnd[CONF_W-1:0];

  // Gesture latches.
  logic [31:0] lft_n, elapsed;
  logic        tmo, grip, trig;
  logic [4:0]  nh;
  always_comb begin
    lft_n   = fist_q ? now_q : lft_q;
    elapsed = now_q - lft_n;
    tmo     = elapsed > {16'd0, cfg_i.grip_timeout_ms};
    grip    = held_q[0];
    trig    = held_q[1];
    if (blk_q) begin
      if (grip && tmo) grip = 1'b0;
    end else if (fist_q) begin
      grip = 1'b1;
    end else if (palm_q) begin
      grip = 1'b0;
      trig = 1'b0;
    end else if (grip && tmo) begin
      grip = 1'b0;
    end
    if (!blk_q && trg_q) trig = 1'b1;
    else if (palm_q || fist_q) trig = 1'b0;
    nh = {btn_q & {3{!blk_q}}, trig, grip};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        prev_pos_q[i] <= '0;
        prev_vel_q[i] <= '0;
      end
      hist_q      <= 1'b0;
      conf_q      <= ONE_Q16;
      blk_q       <= 1'b0;
      lft_q       <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.first) begin
        for (int i = 0; i < 3; i++) begin
          prev_pos_q[i] <= cap_pos_q[i];
          prev_vel_q[i] <= '0;
        end
        hist_q <= 1'b1;
      end
      if (cmd_i.upd) begin
        conf_q <= conf_new;
        if (blk_q) begin
          if (conf_new > cfg_i.unblock_level) blk_q <= 1'b0;
        end else if (conf_new < cfg_i.block_level) begin
          blk_q <= 1'b1;
        end
        for (int i = 0; i < 3; i++) begin
          prev_pos_q[i] <= cap_pos_q[i];
          prev_vel_q[i] <= vel_q[i];
        end
      end
      if (cmd_i.out_load) begin
        lft_q       <= lft_n;
        held_q      <= nh;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pose_q <= pose_i;
      fist_q <= data_i[72];
      palm_q <= data_i[73];
      trg_q  <= data_i[74];
      btn_q  <= data_i[77:75];
      now_q  <= data_i[109:78];
      for (int i = 0; i < 3; i++) begin
        cap_pos_q[i] <= pos_in[i];
        vel_q[i]  <= VEL_W'(pos_in[i]) - VEL_W'(prev_pos_q[i]);
        accl_q[i] <= ACC_W'(VEL_W'(pos_in[i]) - VEL_W'(prev_pos_q[i]))
                     - ACC_W'(prev_vel_q[i]);
      end
    end
    if (cmd_i.acc_en) begin
      sum_q <= (cmd_i.acc_clr ? '0 : sum_q) + SUM_W'(unsigned'(prod));
    end
    if (cmd_i.root_init) begin
      rv_q   <= sum_q;
      rres_q <= '0;
      rbit_q <= SUM_W'(1) << (2 * (ROOT_STEPS - 1));
    end else if (cmd_i.root_step) begin
      if ({1'b0, rv_q} >= rtry) begin
        rv_q   <= rv_q - rtry[SUM_W-1:0];
        rres_q <= (rres_q >> 1) + rbit_q;
      end else begin
        rres_q <= rres_q >> 1;
      end
      rbit_q <= rbit_q >> 2;
    end
    if (cmd_i.div_init) begin
      sat_q <= {3'd0, mag} >= {mid, 6'd0};
      rem_q <= MID_W'(mag >> 6);
      dvd_q <= {mag[5:0], 16'd0};
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      if (dtry >= {1'b0, mid}) begin
        rem_q <= MID_W'(dtry - {1'b0, mid});
        quo_q <= {quo_q[QUO_W-2:0], 1'b1};
      end else begin
        rem_q <= dtry[MID_W-1:0];
        quo_q <= {quo_q[QUO_W-2:0], 1'b0};
      end
      dvd_q <= {dvd_q[QUO_W-2:0], 1'b0};
    end
    if (cmd_i.exp_en) begin
      inst_q <= (sat_q || ip >= 6'd17) ? '0 : (ev >> ip);
    end
    if (cmd_i.out_load) begin
      out_data_q <= {3'd0, conf_q, blk_q, held_q[1] & !nh[1], nh & ~held_q, nh};
    end
  end

  assign status_o.pose       = pose_q;
  assign status_o.hist_valid = hist_q;
  assign status_o.out_free   = !out_valid_q || out_ready_i;
  assign out_valid_o         = out_valid_q;
  assign out_data_o          = out_data_q;

endmodule

// File: src/gesture_button_confidence_gate_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gesture_button_confidence_gate_core: tracking confidence and button gate
// Turns hand tracking frames into held, press and release button masks,
// gated by a smoothed confidence derived from hand acceleration.
// ----------------------------------------------------------------------------
// Usage:
//   One input word per tracking frame arrives on the s_axis channel; tuser
//   says whether the word carries a hand position. One result word per frame
//   leaves on the m_axis channel. Registers are written over the APB port;
//   the user writes them only while no frame is in flight; the block does not enforce it.
//   Sequence: a frame without a position is loaded into the output register
//   from the output state after acceptance; the first position after reset
//   passes the first-pose step first. A frame with a position runs three
//   squares on the shared multiplier, 26 root steps, 22 divide steps, the
//   exponent stage and the smoothing steps before its result is loaded.
//   The next frame is accepted once the controller returns to idle, so a
//   frame is not taken before the previous one is through; the bit-serial
//   root and divide units set most of the time each frame takes.
//   A finished result sits in the output register; a new frame is taken
//   while it waits, and that frame only holds before loading its own result
//   until the receiver takes the earlier one.
//   Reset clears history, gesture latches and the block flag, sets the
//   confidence to 1.0 and loads the register defaults.
// ----------------------------------------------------------------------------
module gesture_button_confidence_gate_core import gbcg_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata, low bit up: pos_x[24], pos_y[24], pos_z[24], closed_fist,
  // open_palm, trigger_in, button_a_in, button_b_in, button_c_in,
  // time_ms[32], two zero bits.
  input  logic [111:0] s_axis_tdata,
  // tuser: pose_present.
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata, low bit up: held_mask[5], press_mask[5], trigger_release,
  // gestures_blocked, confidence_level[17], three zero bits.
  output logic [31:0]  m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  cfg_t    cfg_q;
  cmd_t    cmd;
  status_t status;
  logic    cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Register file; writes to unused addresses fall through.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.accel_midpoint   <= MIDPOINT_RST;
      cfg_q.smoothing_weight <= WEIGHT_RST;
      cfg_q.unblock_level    <= UNBLOCK_RST;
      cfg_q.block_level      <= BLOCK_RST;
      cfg_q.grip_timeout_ms  <= TIMEOUT_RST;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_MIDPOINT: cfg_q.accel_midpoint   <= pwdata[22:0];
        REG_WEIGHT:   cfg_q.smoothing_weight <= pwdata[16:0];
        REG_UNBLOCK:  cfg_q.unblock_level    <= pwdata[16:0];
        REG_BLOCK:    cfg_q.block_level      <= pwdata[16:0];
        REG_TIMEOUT:  cfg_q.grip_timeout_ms  <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_MIDPOINT: prdata = {9'd0, cfg_q.accel_midpoint};
      REG_WEIGHT:   prdata = {15'd0, cfg_q.smoothing_weight};
      REG_UNBLOCK:  prdata = {15'd0, cfg_q.unblock_level};
      REG_BLOCK:    prdata = {15'd0, cfg_q.block_level};
      REG_TIMEOUT:  prdata = {16'd0, cfg_q.grip_timeout_ms};
      default:      prdata = '0;
    endcase
  end

  gbcg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gbcg_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .status_o    (status),
    .pose_i      (s_axis_tuser),
    .data_i      (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// File: sim/tb_gesture_button_confidence_gate_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gesture_button_confidence_gate_core: self-checking bench for the gate
// Drives tracking frames with random gaps, stalls the result side at random,
// predicts every result word from a bit-exact model of the confidence and
// gesture logic and compares each field. Registers are rewritten between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_gesture_button_confidence_gate_core;
  import gbcg_pkg::*;

  typedef struct packed {
    logic        pose;
    logic [31:0] tms;
    logic        bc, bb, ba, trg, palm, fist;
    logic [23:0] z, y, x;
  } frame_t;

  typedef struct packed {
    logic [16:0] conf;
    logic        blk;
    logic        trel;
    logic [4:0]  press;
    logic [4:0]  held;
  } gate_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  gesture_button_confidence_gate_core dut (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Model state: configuration and history, named after the block's behavior.
  logic [22:0] mdl_mid = MIDPOINT_RST;
  logic [16:0] mdl_wt = WEIGHT_RST, mdl_unblk = UNBLOCK_RST, mdl_blk_lvl = BLOCK_RST;
  logic [15:0] mdl_tmo = TIMEOUT_RST;
  logic signed [24:0] last_pos [3];
  logic signed [24:0] last_vel [3];
  logic hist_ok = 0, blocked = 0;
  logic [16:0] conf = ONE_Q16;
  logic [31:0] fist_ms = 0;
  logic [4:0] held_prev = 0;

  frame_t    frames_pending[$];
  gate_out_t results_due[$];
  bit failed = 0;
  int send_idle_pct = 0, recv_stall_pct = 0;
  int hold_off = 0;

  const int unsigned EXP_TAB[17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535,
    48393, 46341, 44380, 42495, 40693, 38968, 37316, 35734, 34219, 32768};

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Updates confidence history for a pose frame, then runs the gesture latches.
  function automatic gate_out_t predict_gate(frame_t f);
    gate_out_t o;
    logic signed [24:0] p [3];
    logic signed [24:0] v [3];
    longint signed a;
    longint unsigned sum, mag, q, inst, w, c, ip;
    int unsigned fr, idx, drop, ev;
    logic grip, trig;
    logic [4:0] nh;
    p[0] = $signed(f.x);
    p[1] = $signed(f.y);
    p[2] = $signed(f.z);
    if (f.pose) begin
      if (!hist_ok) begin
        for (int i = 0; i < 3; i++) begin
          last_pos[i] = p[i];
          last_vel[i] = 0;
        end
        hist_ok = 1;
      end else begin
        sum = 0;
        for (int i = 0; i < 3; i++) begin
          v[i] = p[i] - last_pos[i];
          a = longint'(v[i]) - longint'(last_vel[i]);
          sum += a * a;
        end
        mag = int_sqrt(sum);
        q = (mag << 16) / (mdl_mid == 0 ? 1 : mdl_mid);
        ip = q >> 16;
        fr = 32'(q & 16'hFFFF);
        idx = fr >> 12;
        drop = EXP_TAB[idx] - EXP_TAB[idx + 1];
        ev = EXP_TAB[idx] - ((drop * (fr & 12'hFFF) + 2048) >> 12);
        inst = (ip >= 17) ? 0 : (ev >> ip);
        w = (mdl_wt > ONE_Q16) ? ONE_Q16 : mdl_wt;
        c = (longint'(conf) * (65536 - w) + inst * w + 32768) >> 16;
        if (c > 65536) c = 65536;
        conf = 17'(c);
        if (blocked) begin
          if (conf > mdl_unblk) blocked = 0;
        end else if (conf < mdl_blk_lvl) begin
          blocked = 1;
        end
        for (int i = 0; i < 3; i++) begin
          last_pos[i] = p[i];
          last_vel[i] = v[i];
        end
      end
    end
    grip = held_prev[0];
    trig = held_prev[1];
    if (f.fist) fist_ms = f.tms;
    if (blocked) begin
      if (grip && (f.tms - fist_ms) > mdl_tmo) grip = 0;
    end else if (f.fist) begin
      grip = 1;
    end else if (f.palm) begin
      grip = 0;
      trig = 0;
    end else if (grip && (f.tms - fist_ms) > mdl_tmo) begin
      grip = 0;
    end
    if (!blocked && f.trg) trig = 1;
    else if (f.palm || f.fist) trig = 0;
    nh = {f.bc & !blocked, f.bb & !blocked, f.ba & !blocked, trig, grip};
    o.held = nh;
    o.press = nh & ~held_prev;
    o.trel = held_prev[1] & ~nh[1];
    o.blk = blocked;
    o.conf = conf;
    held_prev = nh;
    return o;
  endfunction

  // Acceptance of the offered word, sampled at the rising edge.
  logic s_axis_tready_q = 1'b0;
  always @(posedge clk_i) s_axis_tready_q <= s_axis_tvalid && s_axis_tready;

  // Driver: offers the oldest pending frame, with random idle cycles.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready_q) begin
        if (frames_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          frame_t f;
          f = frames_pending.pop_front();
          s_axis_tdata <= {2'b00, f[109:0]};
          s_axis_tuser <= f.pose;
          s_axis_tvalid <= 1'b1;
          results_due.push_back(predict_gate(f));
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= (hold_off == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) if (hold_off > 0) hold_off <= hold_off - 1;

  // Monitor: compares each result word with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      gate_out_t got, want;
      got = m_axis_tdata[28:0];
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, got);
        failed = 1;
      end else begin
        want = results_due.pop_front();
        if (got.held !== want.held || got.press !== want.press || got.trel !== want.trel
            || got.blk !== want.blk || got.conf !== want.conf) begin
          $display("%0t: mismatch expected held=%h press=%h rel=%b blk=%b conf=%0d",
                   $time, want.held, want.press, want.trel, want.blk, want.conf);
          $display("%0t:          actual   held=%h press=%h rel=%b blk=%b conf=%0d",
                   $time, got.held, got.press, got.trel, got.blk, got.conf);
          failed = 1;
        end
      end
    end
  end

  // APB write; the block must be idle, so the model is updated alongside.
  task automatic write_reg(reg_idx_e r, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1; pwrite <= 1; paddr <= 5'(r) << 2; pwdata <= val;
    @(negedge clk_i);
    penable <= 1;
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (r)
      REG_MIDPOINT: mdl_mid = val[22:0];
      REG_WEIGHT:   mdl_wt = val[16:0];
      REG_UNBLOCK:  mdl_unblk = val[16:0];
      REG_BLOCK:    mdl_blk_lvl = val[16:0];
      REG_TIMEOUT:  mdl_tmo = val[15:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (frames_pending.size() > 0 || results_due.size() > 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  logic [31:0] clock_ms = 0;
  logic signed [23:0] hx = 0, hy = 0, hz = 0;

  // Random frame: mostly a smooth hand track with small jitter, sometimes a jump.
  task automatic queue_frame(int jitter);
    frame_t f;
    f = '0;
    f.pose = ($urandom_range(9) < 8);
    case ($urandom_range(9))
      0: begin hx = 24'($urandom); hy = 24'($urandom); hz = 24'($urandom); end
      default: begin
        hx = 24'(int'(hx) + int'($urandom_range(2 * jitter)) - jitter);
        hy = 24'(int'(hy) + int'($urandom_range(2 * jitter)) - jitter);
        hz = 24'(int'(hz) + int'($urandom_range(2 * jitter)) - jitter);
      end
    endcase
    f.x = hx; f.y = hy; f.z = hz;
    {f.bc, f.bb, f.ba, f.trg, f.palm} = 5'($urandom);
    f.fist = ($urandom_range(3) == 0);
    clock_ms += $urandom_range(5) == 0 ? $urandom : $urandom_range(200);
    f.tms = clock_ms;
    frames_pending.push_back(f);
  endtask

  initial begin
    frame_t f;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    // Directed frames: no pose, first pose, extremes, every gesture.
    f = '0; f.fist = 1; f.tms = 10; frames_pending.push_back(f);
    f = '0; f.pose = 1; f.x = 24'h7FFFFF; f.y = 24'h800000; f.z = 24'h7FFFFF;
    f.trg = 1; f.tms = 20; frames_pending.push_back(f);
    f = '0; f.pose = 1; f.x = 24'h800000; f.y = 24'h7FFFFF; f.z = 24'h800000;
    f.ba = 1; f.bb = 1; f.bc = 1; f.tms = 30; frames_pending.push_back(f);
    f = '0; f.pose = 1; f.x = 24'h7FFFFF; f.y = 24'h800000; f.z = 24'h7FFFFF;
    f.fist = 1; f.tms = 32'hFFFF_FFFF; frames_pending.push_back(f);
    for (int i = 0; i < 10; i++) begin
      f = '0; f.pose = 1; f.tms = 32'hFFFF_FFFF + 100 * i;
      {f.bc, f.bb, f.ba, f.trg, f.palm, f.fist} = 6'(i * 11);
      frames_pending.push_back(f);
    end
    f = '0; f.palm = 1; f.tms = 5000; frames_pending.push_back(f);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_MIDPOINT, 0); write_reg(REG_WEIGHT, 65536);
          write_reg(REG_UNBLOCK, 0); write_reg(REG_BLOCK, 0); write_reg(REG_TIMEOUT, 0);
        end
        1: begin
          write_reg(REG_MIDPOINT, 23'h7FFFFF); write_reg(REG_WEIGHT, 17'h1FFFF);
          write_reg(REG_UNBLOCK, 17'h1FFFF); write_reg(REG_BLOCK, 17'h1FFFF);
          write_reg(REG_TIMEOUT, 16'hFFFF);
        end
        default: begin
          write_reg(REG_MIDPOINT, $urandom_range(5000, 1));
          write_reg(REG_WEIGHT, $urandom_range(65536));
          write_reg(REG_UNBLOCK, $urandom_range(65536, 30000));
          write_reg(REG_BLOCK, $urandom_range(40000));
          write_reg(REG_TIMEOUT, $urandom_range(600));
        end
      endcase
      send_idle_pct = (ph % 4 == 1) ? 48 : (ph % 4 == 3) ? 38 : 0;
      recv_stall_pct = (ph % 4 == 2) ? 48 : (ph % 4 == 3) ? 38 : 0;
      if (ph == 5) hold_off = 600;
      for (int i = 0; i < 92; i++) queue_frame(ph < 2 ? 4000 : $urandom_range(3000, 10));
      drain();
    end
    if (!failed) begin
      $display("tb_gesture_button_confidence_gate_core: PASS");
    end else begin
      $display("tb_gesture_button_confidence_gate_core: FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_gesture_button_confidence_gate_core: FAIL");
    $finish;
  end

endmodule

// File: filelist.f
src/gbcg_pkg.sv
src/gbcg_ctrl.sv
src/gbcg_datapath.sv
src/gesture_button_confidence_gate_core.sv
sim/tb_gesture_button_confidence_gate_core.sv
